// ===== hw/rtl/wsp_pkg.sv =====
// Shared types and constants for the two-wheel speed PID core.
// No dependencies; imported by every module of the block.
package wsp_pkg;

  localparam int unsigned WheelCount = 2;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 24;

  localparam logic [15:0] PropGainReset   = 16'd512;
  localparam logic [15:0] IntegGainReset  = 16'd128;
  localparam logic [15:0] DerivGainReset  = 16'd0;
  localparam logic [15:0] DriveLowReset   = 16'hfc19;  // -999
  localparam logic [15:0] DriveHighReset  = 16'd999;
  localparam logic [23:0] IntegLimitReset = 24'd128000;

  typedef enum logic [CfgIndexWidth-1:0] {
    RegPropGain   = 3'd0,
    RegIntegGain  = 3'd1,
    RegDerivGain  = 3'd2,
    RegDriveLow   = 3'd3,
    RegDriveHigh  = 3'd4,
    RegIntegLimit = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic signed [23:0] left_goal;
    logic signed [23:0] right_goal;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic signed [15:0] drive_low;
    logic signed [15:0] drive_high;
    logic        [23:0] integ_limit;
  } cfg_t;

  // Pipeline control shared by all lanes.
  typedef struct packed {
    logic tick;     // control beat accepted this cycle
    logic restart;  // restart beat accepted this cycle
    logic en2;      // product stage loads
    logic en3;      // sum stage loads
  } lane_ctrl_t;

endpackage

// ===== hw/rtl/wheel_speed_pid_two_channel_core.sv =====
// Top level of the two-wheel speed PID: config registers, one lane per wheel,
// pipeline control and the output register that merges the lanes' results.
// Depends on wsp_pkg, wsp_cfg_regs and wsp_lane.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   in      | input     | in_valid_i/in_ready_o   | in_data_i  (in_beat_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_beat_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle sustained unless the output stalls; a control beat's result goes
// through speed/error/integral, products, sum, then clamp into the out reg.
// The beat rate is set by the per-wheel state update loop.
// A restart beat clears loop state and yields no result.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stall on the output backs up through the stages; in_ready_o drops only
// when all four stages hold beats.
module wheel_speed_pid_two_channel_core import wsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_beat_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_beat_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  cfg_t       cfg;
  lane_ctrl_t ctrl;

  logic v1_q, v2_q, v3_q, out_valid_q;
  logic en1, en2, en3, en_out, accept;

  logic signed [31:0] pos_a   [WheelCount];
  logic signed [23:0] goal_a  [WheelCount];
  logic signed [15:0] drive_a [WheelCount];
  logic signed [15:0] rate_a  [WheelCount];

  out_beat_t out_q;

  wsp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a stage loads when it is empty or the one after it moves
  assign en_out = !out_valid_q || out_ready_i;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;

  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;

  assign ctrl.tick    = accept && !in_data_i.kind;
  assign ctrl.restart = accept && in_data_i.kind;
  assign ctrl.en2     = en2 && v1_q;
  assign ctrl.en3     = en3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= ctrl.tick;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en_out) out_valid_q <= v3_q;
    end
  end

  assign pos_a[0]  = in_data_i.left_position;
  assign pos_a[1]  = in_data_i.right_position;
  assign goal_a[0] = in_data_i.left_goal;
  assign goal_a[1] = in_data_i.right_goal;

  for (genvar w = 0; w < WheelCount; w++) begin : g_lane
    wsp_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cfg_i      (cfg),
      .position_i (pos_a[w]),
      .goal_i     (goal_a[w]),
      .drive_o    (drive_a[w]),
      .rate_o     (rate_a[w])
    );
  end

  // merge the lanes into one result beat
  always_ff @(posedge clk_i) begin
    if (en_out && v3_q) begin
      out_q.left_drive  <= drive_a[0];
      out_q.right_drive <= drive_a[1];
      out_q.left_rate   <= rate_a[0];
      out_q.right_rate  <= rate_a[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_restart_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.kind) |=> !v1_q)
    else $error("restart beat entered the pipeline");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && out_valid_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  a_no_phantom_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !v3_q) |=> !out_valid_q)
    else $error("result produced without a beat in the sum stage");

endmodule

// ===== hw/rtl/wsp_cfg_regs.sv =====
// Configuration register file: gains, drive bounds and integral limit.
// Depends on wsp_pkg.
module wsp_cfg_regs import wsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegPropGain:   cfg_d.prop_gain   = cfg_data_i[15:0];
        RegIntegGain:  cfg_d.integ_gain  = cfg_data_i[15:0];
        RegDerivGain:  cfg_d.deriv_gain  = cfg_data_i[15:0];
        RegDriveLow:   cfg_d.drive_low   = cfg_data_i[15:0];
        RegDriveHigh:  cfg_d.drive_high  = cfg_data_i[15:0];
        RegIntegLimit: cfg_d.integ_limit = cfg_data_i;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PropGainReset;
      cfg_q.integ_gain  <= IntegGainReset;
      cfg_q.deriv_gain  <= DerivGainReset;
      cfg_q.drive_low   <= DriveLowReset;
      cfg_q.drive_high  <= DriveHighReset;
      cfg_q.integ_limit <= IntegLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/wsp_lane.sv =====
// One wheel's PID datapath: speed, error and integral update, products, sum,
// truncation and drive clamp. Depends on wsp_pkg.
module wsp_lane import wsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctrl_t         ctrl_i,
  input  cfg_t               cfg_i,
  input  logic signed [31:0] position_i,
  input  logic signed [23:0] goal_i,
  output logic signed [15:0] drive_o,
  output logic signed [15:0] rate_o
);

  // loop state
  logic signed [31:0] prev_pos_q;
  logic signed [24:0] integ_q, integ_d;
  logic signed [25:0] prev_err_q;
  logic               first_q;

  // stage 1
  logic signed [25:0] err1_q;
  logic signed [24:0] integ1_q;
  logic signed [26:0] derr1_q;
  logic signed [15:0] rate1_q;
  // stage 2
  logic signed [41:0] p2_q;
  logic signed [40:0] i2_q;
  logic signed [42:0] d2_q;
  logic signed [15:0] rate2_q;
  // stage 3
  logic signed [44:0] acc3_q;
  logic signed [15:0] rate3_q;

  logic signed [32:0] diff;
  logic signed [15:0] rate;
  logic signed [25:0] err;
  logic signed [26:0] isum, lim_s, nlim_s, derr;
  logic signed [44:0] acc_adj;
  logic signed [28:0] quot, drive;

  always_comb begin
    diff = {position_i[31], position_i} - {prev_pos_q[31], prev_pos_q};
    if (diff > 33'sd32767) begin
      rate = 16'sh7fff;
    end else if (diff < -33'sd32768) begin
      rate = 16'sh8000;
    end else begin
      rate = diff[15:0];
    end
    // goal in Q16.8 minus speed scaled to Q16.8
    err  = {{2{goal_i[23]}}, goal_i} - {{2{rate[15]}}, rate, 8'b0};
    isum = {{2{integ_q[24]}}, integ_q} + {err[25], err};
    lim_s  = $signed({3'b000, cfg_i.integ_limit});
    nlim_s = -lim_s;
    if (isum > lim_s) begin
      integ_d = lim_s[24:0];
    end else if (isum < nlim_s) begin
      integ_d = nlim_s[24:0];
    end else begin
      integ_d = isum[24:0];
    end
    // no derivative on the first tick after reset or a restart
    derr = first_q ? '0 : ({err[25], err} - {prev_err_q[25], prev_err_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q <= '0;
      integ_q    <= '0;
      prev_err_q <= '0;
      first_q    <= 1'b1;
    end else if (ctrl_i.restart) begin
      prev_pos_q <= '0;
      integ_q    <= '0;
      prev_err_q <= '0;
      first_q    <= 1'b1;
    end else if (ctrl_i.tick) begin
      prev_pos_q <= position_i;
      integ_q    <= integ_d;
      prev_err_q <= err;
      first_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tick) begin
      err1_q   <= err;
      integ1_q <= integ_d;
      derr1_q  <= derr;
      rate1_q  <= rate;
    end
    if (ctrl_i.en2) begin
      p2_q    <= cfg_i.prop_gain * err1_q;
      i2_q    <= cfg_i.integ_gain * integ1_q;
      d2_q    <= cfg_i.deriv_gain * derr1_q;
      rate2_q <= rate1_q;
    end
    if (ctrl_i.en3) begin
      acc3_q  <= 45'(p2_q) + 45'(i2_q) + 45'(d2_q);
      rate3_q <= rate2_q;
    end
  end

  // divide by 65536 toward zero, then clamp high first, low last
  always_comb begin
    acc_adj = acc3_q + (acc3_q[44] ? 45'sd65535 : 45'sd0);
    quot    = acc_adj[44:16];
    drive   = quot;
    if (drive > 29'(cfg_i.drive_high)) begin
      drive = 29'(cfg_i.drive_high);
    end
    if (drive < 29'(cfg_i.drive_low)) begin
      drive = 29'(cfg_i.drive_low);
    end
  end

  assign drive_o = drive[15:0];
  assign rate_o  = rate3_q;

endmodule
